@@ design/motor_feedback_multiturn_tracker_defines.svh @@
// Assertion macros used by the tracker back end.
`ifndef MOTOR_FEEDBACK_MULTITURN_TRACKER_DEFINES_SVH
`define MOTOR_FEEDBACK_MULTITURN_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define MFT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define MFT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define MFT_ASSERT(label, clk, rst, prop)
`define MFT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ design/mft_pkg.sv @@
// Shared types and constants of the multi-turn feedback tracker.
package mft_pkg;
   localparam int          ANGLE_BITS = 13;
   localparam int          TURNS_OUT_BITS = 24;
   localparam int          POS_BITS = ANGLE_BITS + TURNS_OUT_BITS;
   localparam logic [10:0] BASE_ID = 11'h201;
   localparam int          HALF_TURN = 4096;

   typedef struct packed {
      logic                   valid_res;
      logic [2:0]             motor;
      logic [ANGLE_BITS-1:0]  angle;
      logic signed [15:0]     speed;
      logic signed [15:0]     current;
      logic signed [7:0]      temperature;
   } item_type;
endpackage

@@ design/mft_front.sv @@
// Front end: decodes a feedback frame and classifies its identifier.
module mft_front
   import mft_pkg::*;
#(
   parameter int NUM_MOTORS = 8
) (
   input  logic [10:0] frame_id,
   input  logic [7:0]  angle_high,
   input  logic [7:0]  angle_low,
   input  logic [7:0]  speed_high,
   input  logic [7:0]  speed_low,
   input  logic [7:0]  current_high,
   input  logic [7:0]  current_low,
   input  logic [7:0]  temp_byte,
   output item_type    item
);
   localparam logic [11:0] LAST_ID = 12'(BASE_ID) + 12'(NUM_MOTORS);

   logic       hit;
   logic [2:0] offset;

   assign hit    = (frame_id >= BASE_ID) && ({1'b0, frame_id} < LAST_ID);
   assign offset = 3'(frame_id - BASE_ID);

   // Frames for other identifiers travel on with every field cleared.
   always_comb begin
      item = '0;
      if (hit) begin
         item.valid_res   = 1'b1;
         item.motor       = offset;
         item.angle       = {angle_high[4:0], angle_low};
         item.speed       = {speed_high, speed_low};
         item.current     = {current_high, current_low};
         item.temperature = temp_byte;
      end
   end
endmodule

@@ design/mft_queue.sv @@
// Two-entry queue between the decode front end and the tracking back end.
module mft_queue
   import mft_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);
   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule

@@ design/mft_back.sv @@
// Back end: per-motor turn tracking, position unwrap and output register.
`include "motor_feedback_multiturn_tracker_defines.svh"
module mft_back
   import mft_pkg::*;
#(
   parameter int NUM_MOTORS = 8,
   parameter int TURN_BITS  = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   output logic                       head_ready,
   input  item_type                   head_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output item_type                   rsp_item,
   output logic signed [TURNS_OUT_BITS-1:0] rsp_turns,
   output logic signed [POS_BITS-1:0] rsp_position
);
   localparam int IDX_BITS = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

   logic                        first_ff [NUM_MOTORS];
   logic [ANGLE_BITS-1:0]       start_ff [NUM_MOTORS];
   logic [ANGLE_BITS-1:0]       last_ff  [NUM_MOTORS];
   logic [TURN_BITS-1:0]        turn_ff  [NUM_MOTORS];

   logic                        out_valid_ff, out_valid_in;
   item_type                    out_item_ff;
   logic signed [TURNS_OUT_BITS-1:0] out_turns_ff, out_turns_in;
   logic signed [POS_BITS-1:0]  out_pos_ff, out_pos_in;

   logic                        take, update;
   logic [IDX_BITS-1:0]         idx;
   logic [ANGLE_BITS-1:0]       cur_start, cur_last;
   logic [TURN_BITS-1:0]        cur_turn, new_turn;
   logic signed [ANGLE_BITS:0]  diff;

   assign head_ready   = !out_valid_ff || rsp_ready;
   assign take         = head_valid && head_ready;
   assign update       = take && head_item.valid_res;
   assign idx          = head_item.motor[IDX_BITS-1:0];
   assign rsp_valid    = out_valid_ff;
   assign rsp_item     = out_item_ff;
   assign rsp_turns    = out_turns_ff;
   assign rsp_position = out_pos_ff;

   // On a motor's first frame the stored angles are replaced by the current one,
   // so the jump test sees no motion.
   always_comb begin
      cur_start = first_ff[idx] ? head_item.angle : start_ff[idx];
      cur_last  = first_ff[idx] ? head_item.angle : last_ff[idx];
      cur_turn  = first_ff[idx] ? '0 : turn_ff[idx];
      diff      = $signed({1'b0, head_item.angle}) - $signed({1'b0, cur_last});
      if (diff > (ANGLE_BITS+1)'(HALF_TURN)) begin
         new_turn = cur_turn - TURN_BITS'(1);
      end else if (diff < -(ANGLE_BITS+1)'(HALF_TURN)) begin
         new_turn = cur_turn + TURN_BITS'(1);
      end else begin
         new_turn = cur_turn;
      end
      out_turns_in = TURNS_OUT_BITS'($signed(new_turn));
      out_pos_in   = $signed({out_turns_in, {ANGLE_BITS{1'b0}}})
                     + $signed(POS_BITS'(head_item.angle))
                     - $signed(POS_BITS'(cur_start));
      if (!head_item.valid_res) begin
         out_turns_in = '0;
         out_pos_in   = '0;
      end
      out_valid_in = take ? 1'b1 : (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MOTORS; i++) begin
            first_ff[i] <= 1'b1;
            start_ff[i] <= '0;
            last_ff[i]  <= '0;
            turn_ff[i]  <= '0;
         end
      end else if (update) begin
         first_ff[idx] <= 1'b0;
         start_ff[idx] <= cur_start;
         last_ff[idx]  <= head_item.angle;
         turn_ff[idx]  <= new_turn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_item_ff  <= head_item;
         out_turns_ff <= out_turns_in;
         out_pos_ff   <= out_pos_in;
      end
   end

   `MFT_ASSERT(a_take_shows_result, clock, reset, take |=> rsp_valid)
   `MFT_ASSERT(a_first_cleared, clock, reset, update |=> !first_ff[$past(idx)])
   `MFT_ASSERT(a_miss_is_zero, clock, reset,
      (rsp_valid && !rsp_item.valid_res) |-> (rsp_position == '0 && rsp_turns == '0))
endmodule

@@ design/motor_feedback_multiturn_tracker.sv @@
// A frame's result passes through a queue entry, then is registered in the output register.
// Throughput: one frame per cycle while the result channel is ready; the per-motor turn
// update and the position add are combinational; a two-entry queue decouples the two sides.
// A stalled result channel holds the queue; up to two more frames are taken meanwhile.
// Reset (synchronous, active high) empties the queue and output and marks every
// motor as awaiting its first frame with zero turns.
module motor_feedback_multiturn_tracker
   import mft_pkg::*;
#(
   parameter int NUM_MOTORS = 8,
   parameter int TURN_BITS  = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [10:0]        req_frame_id,
   input  logic [7:0]         req_angle_high,
   input  logic [7:0]         req_angle_low,
   input  logic [7:0]         req_speed_high,
   input  logic [7:0]         req_speed_low,
   input  logic [7:0]         req_current_high,
   input  logic [7:0]         req_current_low,
   input  logic [7:0]         req_temp_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_valid_res,
   output logic [2:0]         rsp_motor,
   output logic [12:0]        rsp_angle,
   output logic signed [15:0] rsp_speed,
   output logic signed [15:0] rsp_current,
   output logic signed [7:0]  rsp_temperature,
   output logic signed [23:0] rsp_turns,
   output logic signed [36:0] rsp_position
);
   item_type dec_item, head_item, out_item;
   logic     head_valid, head_ready;

   mft_front #(.NUM_MOTORS(NUM_MOTORS)) u_front (
      .frame_id     (req_frame_id),
      .angle_high   (req_angle_high),
      .angle_low    (req_angle_low),
      .speed_high   (req_speed_high),
      .speed_low    (req_speed_low),
      .current_high (req_current_high),
      .current_low  (req_current_low),
      .temp_byte    (req_temp_byte),
      .item         (dec_item)
   );

   mft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (dec_item),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_item   (head_item)
   );

   mft_back #(.NUM_MOTORS(NUM_MOTORS), .TURN_BITS(TURN_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_ready   (head_ready),
      .head_item    (head_item),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_item     (out_item),
      .rsp_turns    (rsp_turns),
      .rsp_position (rsp_position)
   );

   assign rsp_valid_res   = out_item.valid_res;
   assign rsp_motor       = out_item.motor;
   assign rsp_angle       = out_item.angle;
   assign rsp_speed       = out_item.speed;
   assign rsp_current     = out_item.current;
   assign rsp_temperature = out_item.temperature;
endmodule

@@ tb/sv/motor_feedback_multiturn_tracker_tb.sv @@
// Self-checking testbench for the multi-turn motor feedback tracker with a scoreboard class.
module motor_feedback_multiturn_tracker_tb;
   import mft_pkg::*;

   localparam int MOTOR_COUNT = 8;
   localparam int RANDOM_PER_PHASE = 217;

   typedef struct packed {
      item_type               base;
      logic signed [23:0]     turns;
      logic signed [36:0]     position;
   } tracker_result_type;

   // Tracks per-motor unwrap state and holds the expected results in transfer order.
   class position_scoreboard;
      bit                 awaiting_first[MOTOR_COUNT];
      logic [12:0]        start_ang[MOTOR_COUNT];
      logic [12:0]        last_ang[MOTOR_COUNT];
      logic [23:0]        turn_cnt[MOTOR_COUNT];
      tracker_result_type expected_fb[$];
      int                 mismatches;
      int                 results_seen;

      function new();
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            awaiting_first[i] = 1'b1;
            start_ang[i] = '0;
            last_ang[i] = '0;
            turn_cnt[i] = '0;
         end
         mismatches = 0;
         results_seen = 0;
      endfunction

      function void note_frame(input logic [10:0] id, input logic [7:0] ah, al, sh, sl,
                               ch, cl, tp);
         tracker_result_type r;
         logic [12:0]        ang;
         logic [36:0]        turns_wide;
         int                 diff;
         int                 m;
         r = '0;
         if (int'(id) >= int'(BASE_ID) && int'(id) < int'(BASE_ID) + MOTOR_COUNT) begin
            m = int'(id) - int'(BASE_ID);
            // Only the low 13 bits of the payload angle are meaningful.
            ang = {ah[4:0], al};
            if (awaiting_first[m]) begin
               start_ang[m] = ang;
               last_ang[m] = ang;
               turn_cnt[m] = '0;
               awaiting_first[m] = 1'b0;
            end
            diff = int'(ang) - int'(last_ang[m]);
            if (diff > HALF_TURN) begin
               turn_cnt[m] = turn_cnt[m] - 24'd1;
            end else if (diff < -HALF_TURN) begin
               turn_cnt[m] = turn_cnt[m] + 24'd1;
            end
            last_ang[m] = ang;
            turns_wide = {{13{turn_cnt[m][23]}}, turn_cnt[m]};
            r.base.valid_res = 1'b1;
            r.base.motor = m[2:0];
            r.base.angle = ang;
            r.base.speed = {sh, sl};
            r.base.current = {ch, cl};
            r.base.temperature = tp;
            r.turns = turn_cnt[m];
            r.position = (turns_wide << 13) + {24'b0, ang} - {24'b0, start_ang[m]};
         end
         expected_fb.push_back(r);
      endfunction

      task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
         if (mismatches < 100) begin
            $display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, what, got,
                     want);
         end
         mismatches++;
      endtask

      task check_result(input tracker_result_type got);
         tracker_result_type want;
         if (expected_fb.size() == 0) begin
            report_mismatch("unexpected result", 64'(got.base.motor), 64'd0);
         end else begin
            want = expected_fb.pop_front();
            if (got.base.valid_res !== want.base.valid_res)
               report_mismatch("valid_res", 64'(got.base.valid_res), 64'(want.base.valid_res));
            if (got.base.motor !== want.base.motor)
               report_mismatch("motor", 64'(got.base.motor), 64'(want.base.motor));
            if (got.base.angle !== want.base.angle)
               report_mismatch("angle", 64'(got.base.angle), 64'(want.base.angle));
            if (got.base.speed !== want.base.speed)
               report_mismatch("speed", 64'(got.base.speed), 64'(want.base.speed));
            if (got.base.current !== want.base.current)
               report_mismatch("current", 64'(got.base.current), 64'(want.base.current));
            if (got.base.temperature !== want.base.temperature)
               report_mismatch("temperature", 64'(got.base.temperature),
                               64'(want.base.temperature));
            if (got.turns !== want.turns)
               report_mismatch("turns", 64'(got.turns), 64'(want.turns));
            if (got.position !== want.position)
               report_mismatch("position", 64'(got.position), 64'(want.position));
         end
         results_seen++;
      endtask

      task check_drained();
         if (expected_fb.size() != 0)
            report_mismatch("results never delivered", 64'(expected_fb.size()), 64'd0);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [10:0] req_frame_id;
   logic [7:0]  req_angle_high;
   logic [7:0]  req_angle_low;
   logic [7:0]  req_speed_high;
   logic [7:0]  req_speed_low;
   logic [7:0]  req_current_high;
   logic [7:0]  req_current_low;
   logic [7:0]  req_temp_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_valid_res;
   logic [2:0]  rsp_motor;
   logic [12:0] rsp_angle;
   logic signed [15:0] rsp_speed;
   logic signed [15:0] rsp_current;
   logic signed [7:0]  rsp_temperature;
   logic signed [23:0] rsp_turns;
   logic signed [36:0] rsp_position;

   position_scoreboard sb;
   int idle_pct;
   int stall_pct;
   int track_ang[MOTOR_COUNT];
   int drift[MOTOR_COUNT];

   motor_feedback_multiturn_tracker dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_frame_id     (req_frame_id),
      .req_angle_high   (req_angle_high),
      .req_angle_low    (req_angle_low),
      .req_speed_high   (req_speed_high),
      .req_speed_low    (req_speed_low),
      .req_current_high (req_current_high),
      .req_current_low  (req_current_low),
      .req_temp_byte    (req_temp_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_motor        (rsp_motor),
      .rsp_angle        (rsp_angle),
      .rsp_speed        (rsp_speed),
      .rsp_current      (rsp_current),
      .rsp_temperature  (rsp_temperature),
      .rsp_turns        (rsp_turns),
      .rsp_position     (rsp_position)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      tracker_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.base.valid_res = rsp_valid_res;
         got.base.motor = rsp_motor;
         got.base.angle = rsp_angle;
         got.base.speed = rsp_speed;
         got.base.current = rsp_current;
         got.base.temperature = rsp_temperature;
         got.turns = rsp_turns;
         got.position = rsp_position;
         sb.check_result(got);
      end
   end

   // Drives one frame from a falling edge and returns at the falling edge after its transfer.
   task send_frame(input logic [10:0] id, input logic [7:0] ah, al, sh, sl, ch, cl, tp);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_frame_id <= id;
      req_angle_high <= ah;
      req_angle_low <= al;
      req_speed_high <= sh;
      req_speed_low <= sl;
      req_current_high <= ch;
      req_current_low <= cl;
      req_temp_byte <= tp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_frame(id, ah, al, sh, sl, ch, cl, tp);
      @(negedge clock);
   endtask

   // Mostly a motor turning steadily with occasional jumps; the rest is bus noise.
   task send_random_frame();
      logic [10:0] id;
      logic [12:0] ang;
      logic [2:0]  upper;
      int          m;
      if ($urandom_range(99) < 80) begin
         m = $urandom_range(MOTOR_COUNT - 1);
         if ($urandom_range(9) == 0) begin
            track_ang[m] = $urandom_range(8191);
         end else begin
            track_ang[m] = (track_ang[m] + int'($urandom_range(3000)) - 1500 + drift[m]
                            + 8192) & 8191;
         end
         ang = track_ang[m][12:0];
         upper = $urandom_range(1) ? 3'($urandom_range(7)) : 3'd0;
         id = BASE_ID + 11'(m);
         send_frame(id, {upper, ang[12:8]}, ang[7:0], 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
         if ($urandom_range(4) == 0)
            id = BASE_ID + 11'($urandom_range(MOTOR_COUNT - 1));
         else
            id = 11'($urandom_range(2047));
         send_frame(id, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      int waited;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_frame_id = '0;
      req_angle_high = '0;
      req_angle_low = '0;
      req_speed_high = '0;
      req_speed_low = '0;
      req_current_high = '0;
      req_current_low = '0;
      req_temp_byte = '0;
      rsp_ready = 1'b0;
      idle_pct = 6;
      stall_pct = 84;
      sb = new();
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         track_ang[i] = $urandom_range(8191);
         drift[i] = int'($urandom_range(2400)) - 1200;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Identifiers just outside the motor range and at the extremes are ignored.
      send_frame(11'h000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_frame(11'h7FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_frame(11'h200, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE);
      send_frame(11'h209, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE);
      // Motor 0: first frame at 8000, then wraps forward and back, then the half-turn edges.
      send_frame(11'h201, 8'h1F, 8'h40, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'h7F);
      send_frame(11'h201, 8'h00, 8'h64, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'h80);
      send_frame(11'h201, 8'h1F, 8'h40, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFF);
      send_frame(11'h201, 8'h0F, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_frame(11'h201, 8'h1F, 8'h41, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h01);
      // Motor 1: raw angle above the 13-bit range is masked.
      send_frame(11'h202, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A);
      send_frame(11'h202, 8'hE0, 8'h00, 8'h43, 8'h21, 8'h87, 8'h65, 8'h0F);
      // Motor 7: start at zero and step down through the wrap to position minus one.
      send_frame(11'h208, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_frame(11'h208, 8'h1F, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      for (int m = 2; m < 7; m++) begin
         send_frame(BASE_ID + 11'(m), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            idle_pct = 84;
            stall_pct = 6;
         end else if (phase == 2) begin
            idle_pct = 0;
            stall_pct = 0;
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random_frame();
      end
      req_valid <= 1'b0;

      waited = 0;
      while (sb.expected_fb.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      sb.check_drained();
      if (sb.mismatches == 0) begin
         $display("motor_feedback_multiturn_tracker_tb passed");
      end else begin
         $display("motor_feedback_multiturn_tracker_tb failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("motor_feedback_multiturn_tracker_tb failed");
      $finish;
   end
endmodule
